// ===== src/ukl_pkg.sv =====
// ----------------------------------------------------------------------------
// ukl_pkg: shared definitions for the unique key list table
// Table size, operation and status codes, the sequencer state and the
// per-cell control bundle.
// ----------------------------------------------------------------------------
package ukl_pkg;

  // Table size and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the item ports.
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int ENTRY_W  = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  // Sequencer state.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ukl_state_t;

  // Control bundle handed to each cell.
  typedef struct packed {
    logic capture;    // compare the incoming key and hold the result
    logic write_new;  // store the key being inserted
    logic shift;      // take the neighbour's key if at or beyond the hit
  } ukl_cell_ctrl_t;

endpackage

// ===== src/ukl_cell.sv =====
// ----------------------------------------------------------------------------
// ukl_cell: one slot of the key table
// Holds one key, compares it with an incoming item's key and, on removal,
// takes its upper neighbour's key so that the table stays packed.
// ----------------------------------------------------------------------------
module ukl_cell (
  input  logic                          clk,
  input  ukl_pkg::ukl_cell_ctrl_t       ctrl,
  input  logic                          live,
  input  logic [ukl_pkg::KEY_W-1:0]     probe_key,
  input  logic [ukl_pkg::KEY_W-1:0]     new_key,
  input  logic [ukl_pkg::KEY_W-1:0]     next_key,
  input  logic                          seen_in,
  output logic [ukl_pkg::KEY_W-1:0]     key_q,
  output logic                          match_q,
  output logic                          seen_out
);

  logic [ukl_pkg::KEY_W-1:0] key_r;
  logic                      match_r;

  // The hit flag ripples upwards: set in the matching cell and all above it.
  assign seen_out = seen_in | match_r;
  assign key_q    = key_r;
  assign match_q  = match_r;

  // Match flag, taken when an item is accepted.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      match_r <= live && (key_r == probe_key);
    end
  end

  // Key storage: written on insert, or shifted down on remove.
  always_ff @(posedge clk) begin
    if (ctrl.write_new) begin
      key_r <= new_key;
    end else if (ctrl.shift && seen_out) begin
      key_r <= next_key;
    end
  end

endmodule

// ===== src/unique_key_list_table_core.sv =====
// ----------------------------------------------------------------------------
// unique_key_list_table_core: bounded table of unique signed keys
// Search, insert and remove on a packed, insertion-ordered row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per operation (in_operation, in_key);
//   the result channel returns one item per input (out_status, out_position,
//   out_entry_count). Both use valid/stall: an item moves on a clock edge
//   with valid high and stall low.
//   Each item is handled in turn: in the accepting cycle every cell
//   compares its key with in_key in parallel and holds the hit flag; then,
//   in the execute state, the hit is encoded, the status formed and the
//   cells updated (insert writes the slot at the current count, remove
//   shifts every cell at or above the hit down by one). The result is
//   registered, and a new item is taken only once the last has executed.
//   in_stall is high while an item is being executed. When the receiver
//   stalls and a result is still waiting, execution of the next item holds
//   in the execute state until the output register frees.
//   Synchronous reset empties the table (count zero) and drops any pending
//   result; stored keys are not cleared, as only live slots are compared.
// ----------------------------------------------------------------------------
module unique_key_list_table_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ukl_pkg::OP_W-1:0]        in_operation,
  input  logic signed [ukl_pkg::KEY_W-1:0] in_key,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ukl_pkg::STATUS_W-1:0]    out_status,
  output logic [ukl_pkg::POS_W-1:0]       out_position,
  output logic [ukl_pkg::ENTRY_W-1:0]     out_entry_count
);

  localparam int N = ukl_pkg::CAPACITY;

  ukl_pkg::ukl_state_t               state_r, state_nxt;
  logic [ukl_pkg::OP_W-1:0]          op_r;
  logic [ukl_pkg::KEY_W-1:0]         key_r;
  logic [ukl_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                              out_valid_r;
  logic [ukl_pkg::STATUS_W-1:0]      status_r, status_nxt;
  logic [ukl_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic [ukl_pkg::ENTRY_W-1:0]       entry_r;

  logic                              capture;
  logic                              fire;
  logic                              do_insert;
  logic                              do_remove;
  logic                              any_hit;
  logic [ukl_pkg::IDX_W-1:0]         hit_idx;

  logic [ukl_pkg::KEY_W-1:0]         cell_key [N];
  logic [N-1:0]                      cell_match;
  logic [N:0]                        seen;
  ukl_pkg::ukl_cell_ctrl_t           cell_ctrl [N];

  // Handshake and sequencing controls.
  always_comb begin
    capture  = 1'b0;
    fire     = 1'b0;
    in_stall = 1'b1;
    unique case (state_r)
      ukl_pkg::S_IDLE: begin
        in_stall = 1'b0;
        capture  = in_valid;
      end
      ukl_pkg::S_EXEC: begin
        fire = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ukl_pkg::S_IDLE: if (in_valid) state_nxt = ukl_pkg::S_EXEC;
      ukl_pkg::S_EXEC: if (fire) state_nxt = ukl_pkg::S_IDLE;
      default:         state_nxt = ukl_pkg::S_IDLE;
    endcase
  end

  // The keys are unique, so at most one cell hits: OR the indices together.
  always_comb begin
    any_hit = seen[N];
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (cell_match[i]) begin
        hit_idx = hit_idx | ukl_pkg::IDX_W'(i);
      end
    end
  end

  // Status, position and count update for the item in execution.
  always_comb begin
    status_nxt = ukl_pkg::ST_NOT_FOUND;
    pos_nxt    = '0;
    count_nxt  = count_r;
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    unique case (op_r)
      ukl_pkg::OP_SEARCH: begin
        if (any_hit) begin
          status_nxt = ukl_pkg::ST_OK;
          pos_nxt    = ukl_pkg::POS_W'(hit_idx);
        end
      end
      ukl_pkg::OP_INSERT: begin
        if (count_r == ukl_pkg::CNT_W'(N)) begin
          status_nxt = ukl_pkg::ST_FULL;
        end else if (any_hit) begin
          status_nxt = ukl_pkg::ST_DUPLICATE;
        end else begin
          status_nxt = ukl_pkg::ST_OK;
          pos_nxt    = ukl_pkg::POS_W'(count_r);
          count_nxt  = count_r + ukl_pkg::CNT_W'(1);
          do_insert  = 1'b1;
        end
      end
      ukl_pkg::OP_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = ukl_pkg::ST_EMPTY;
        end else if (any_hit) begin
          status_nxt = ukl_pkg::ST_OK;
          pos_nxt    = ukl_pkg::POS_W'(hit_idx);
          count_nxt  = count_r - ukl_pkg::CNT_W'(1);
          do_remove  = 1'b1;
        end
      end
      default: begin
        status_nxt = ukl_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Row of cells; each hands its key to the cell below and the hit flag up.
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [ukl_pkg::KEY_W-1:0] upper_key;

    if (g == N - 1) begin : g_top
      assign upper_key = '0;
    end else begin : g_mid
      assign upper_key = cell_key[g+1];
    end

    assign cell_ctrl[g].capture   = capture;
    assign cell_ctrl[g].write_new = fire && do_insert && (count_r == ukl_pkg::CNT_W'(g));
    assign cell_ctrl[g].shift     = fire && do_remove;

    ukl_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .live      (ukl_pkg::CNT_W'(g) < count_r),
      .probe_key (in_key),
      .new_key   (key_r),
      .next_key  (upper_key),
      .seen_in   (seen[g]),
      .key_q     (cell_key[g]),
      .match_q   (cell_match[g]),
      .seen_out  (seen[g+1])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ukl_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (capture) begin
      op_r  <= in_operation;
      key_r <= in_key;
    end
    if (fire) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
      entry_r  <= ukl_pkg::ENTRY_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = pos_r;
  assign out_entry_count = entry_r;

endmodule

// ===== src/ukl_checker.sv =====
// ----------------------------------------------------------------------------
// ukl_checker: port-level checks for the unique key list table
// Watches the top level's ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
module ukl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ukl_pkg::STATUS_W-1:0]    out_status,
  input logic [ukl_pkg::POS_W-1:0]       out_position,
  input logic [ukl_pkg::ENTRY_W-1:0]     out_entry_count
);

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_position) && $stable(out_entry_count))
    else $error("stalled result item changed");

  // An accepted item keeps the input side busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // A failed operation reports position zero.
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ukl_pkg::ST_OK) |-> out_position == '0)
    else $error("non-zero position on a failed operation");

  // Full and empty reports agree with the entry count.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != ukl_pkg::ST_FULL
        || out_entry_count == ukl_pkg::ENTRY_W'(ukl_pkg::CAPACITY))
      && (out_status != ukl_pkg::ST_EMPTY || out_entry_count == '0))
    else $error("entry count disagrees with full or empty status");

endmodule

bind unique_key_list_table_core ukl_checker u_ukl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_position    (out_position),
  .out_entry_count (out_entry_count)
);

// ===== verif/tb_unique_key_list_table_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unique_key_list_table_core: self-checking bench for the unique key table
// Walks a short table of directed items covering the empty, full, duplicate
// and absent-key cases, then runs phases of random fill, drain and mixed
// traffic. A behavioural copy of the table predicts every result, and each
// returned item is compared field by field with the oldest prediction.
// Random idle bursts are applied on both channels, with a quiet final stretch.
// ----------------------------------------------------------------------------
module tb_unique_key_list_table_core;

  // The operation code that the block treats as a no-op.
  localparam logic [ukl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 1725;
  localparam int QUIET_TAIL     = 150;
  localparam int PHASE_LEN      = 64;
  localparam int POOL_SIZE      = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_REPORTS    = 10;

  typedef enum {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_kind_t;

  typedef struct packed {
    logic [ukl_pkg::STATUS_W-1:0] status;
    logic [ukl_pkg::POS_W-1:0]    position;
    logic [ukl_pkg::ENTRY_W-1:0]  entry_count;
  } table_result_t;

  typedef struct {
    logic [ukl_pkg::OP_W-1:0]         op;
    logic signed [ukl_pkg::KEY_W-1:0] key;
    bit                               fixed;
    table_result_t                    result;
  } stim_row_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [ukl_pkg::OP_W-1:0]         in_operation = ukl_pkg::OP_SEARCH;
  logic signed [ukl_pkg::KEY_W-1:0] in_key = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [ukl_pkg::STATUS_W-1:0]     out_status;
  logic [ukl_pkg::POS_W-1:0]        out_position;
  logic [ukl_pkg::ENTRY_W-1:0]      out_entry_count;

  // Typed expectation that travels with the item currently offered.
  bit            row_fixed = 1'b0;
  table_result_t row_result = '0;

  // Predicted table contents and the queue of results still awaited.
  logic signed [ukl_pkg::KEY_W-1:0] table_keys [ukl_pkg::CAPACITY];
  int                               table_count = 0;
  table_result_t                    awaited_results [$];
  stim_row_t                        directed_rows [$];

  // Idling control and bookkeeping.
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int op_seen [4] = '{default: 0};
  int status_seen [8] = '{default: 0};

  unique_key_list_table_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one operation to the predicted table and returns its result.
  function automatic table_result_t apply_operation(
      input logic [ukl_pkg::OP_W-1:0] op,
      input logic signed [ukl_pkg::KEY_W-1:0] key);
    table_result_t res;
    int            hit;
    int            i;
    res.status   = ukl_pkg::ST_NOT_FOUND;
    res.position = '0;
    hit = -1;
    for (i = 0; i < table_count; i++) begin
      if (hit < 0 && table_keys[i] == key) hit = i;
    end
    case (op)
      ukl_pkg::OP_SEARCH: begin
        if (hit >= 0) begin
          res.status   = ukl_pkg::ST_OK;
          res.position = ukl_pkg::POS_W'(hit);
        end
      end
      ukl_pkg::OP_INSERT: begin
        // Fullness takes precedence over a duplicate key.
        if (table_count >= ukl_pkg::CAPACITY) begin
          res.status = ukl_pkg::ST_FULL;
        end else if (hit >= 0) begin
          res.status = ukl_pkg::ST_DUPLICATE;
        end else begin
          table_keys[table_count] = key;
          res.position = ukl_pkg::POS_W'(table_count);
          table_count++;
          res.status = ukl_pkg::ST_OK;
        end
      end
      ukl_pkg::OP_REMOVE: begin
        if (table_count == 0) begin
          res.status = ukl_pkg::ST_EMPTY;
        end else if (hit >= 0) begin
          // Close the gap by moving every later entry down one place.
          for (i = hit; i < table_count - 1; i++) table_keys[i] = table_keys[i + 1];
          table_count--;
          res.position = ukl_pkg::POS_W'(hit);
          res.status   = ukl_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    res.entry_count = ukl_pkg::ENTRY_W'(table_count);
    return res;
  endfunction

  // Appends one row to the directed stimulus table.
  function automatic void add_row(input logic [ukl_pkg::OP_W-1:0] op,
                                  input logic signed [ukl_pkg::KEY_W-1:0] key,
                                  input bit fixed,
                                  input logic [ukl_pkg::STATUS_W-1:0] status,
                                  input logic [ukl_pkg::POS_W-1:0] position,
                                  input logic [ukl_pkg::ENTRY_W-1:0] entry_count);
    stim_row_t row;
    row.op     = op;
    row.key    = key;
    row.fixed  = fixed;
    row.result = {status, position, entry_count};
    directed_rows.push_back(row);
  endfunction

  // Offers one item after an optional random gap and waits for acceptance.
  task automatic send_item(input logic [ukl_pkg::OP_W-1:0] op,
                           input logic signed [ukl_pkg::KEY_W-1:0] key,
                           input bit fixed, input table_result_t result);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation <= op;
    in_key       <= key;
    row_fixed    <= fixed;
    row_result   <= result;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stalls in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Checks returned items, then predicts the result of any accepted item.
  always @(posedge clk) begin
    table_result_t seen;
    table_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen = {out_status, out_position, out_entry_count};
        results_seen++;
        status_seen[out_status]++;
        if (awaited_results.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: status %0d position %0d count %0d",
                     seen.status, seen.position, seen.entry_count);
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected status %0d position %0d count %0d, %s %0d %0d %0d",
                       want.status, want.position, want.entry_count, "got",
                       seen.status, seen.position, seen.entry_count);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_operation(in_operation, in_key);
        if (row_fixed) want = row_result;
        awaited_results.push_back(want);
        op_seen[in_operation]++;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed table, then phases of random traffic.
  initial begin
    logic signed [ukl_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    logic signed [ukl_pkg::KEY_W-1:0] key;
    logic [ukl_pkg::OP_W-1:0]         op;
    phase_kind_t                      phase;
    int                               r;
    int                               n;
    int                               i;

    // Empty table, unused code, extremes, duplicate and absent keys.
    add_row(ukl_pkg::OP_SEARCH, 0, 1'b1, ukl_pkg::ST_NOT_FOUND, 4'd0, 5'd0);
    add_row(ukl_pkg::OP_REMOVE, 5, 1'b1, ukl_pkg::ST_EMPTY, 4'd0, 5'd0);
    add_row(OP_UNUSED, -1, 1'b1, ukl_pkg::ST_NOT_FOUND, 4'd0, 5'd0);
    add_row(ukl_pkg::OP_INSERT, 32'h8000_0000, 1'b1, ukl_pkg::ST_OK, 4'd0, 5'd1);
    add_row(ukl_pkg::OP_INSERT, 32'h7fff_ffff, 1'b1, ukl_pkg::ST_OK, 4'd1, 5'd2);
    add_row(ukl_pkg::OP_INSERT, 32'h8000_0000, 1'b1, ukl_pkg::ST_DUPLICATE, 4'd0, 5'd2);
    add_row(ukl_pkg::OP_INSERT, -1, 1'b1, ukl_pkg::ST_OK, 4'd2, 5'd3);
    add_row(ukl_pkg::OP_INSERT, 0, 1'b1, ukl_pkg::ST_OK, 4'd3, 5'd4);
    add_row(ukl_pkg::OP_REMOVE, 12345, 1'b1, ukl_pkg::ST_NOT_FOUND, 4'd0, 5'd4);
    add_row(ukl_pkg::OP_REMOVE, 32'h7fff_ffff, 1'b1, ukl_pkg::ST_OK, 4'd1, 5'd3);
    // Fill to capacity with distinct keys.
    for (i = 0; i < ukl_pkg::CAPACITY - 3; i++)
      add_row(ukl_pkg::OP_INSERT, 32'h0101_0101 * (i + 1), 1'b0, ukl_pkg::ST_OK,
              4'd0, 5'd0);
    // A full table reports full even for a key it holds; removing the head shifts all.
    add_row(ukl_pkg::OP_INSERT, 32'h8000_0000, 1'b1, ukl_pkg::ST_FULL, 4'd0, 5'd16);
    add_row(ukl_pkg::OP_REMOVE, 32'h8000_0000, 1'b1, ukl_pkg::ST_OK, 4'd0, 5'd15);

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[j])
      send_item(directed_rows[j].op, directed_rows[j].key, directed_rows[j].fixed,
                directed_rows[j].result);

    phase = PH_MIXED;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // New phase: traffic shape, idling and a fresh set of candidate keys.
      if (n % PHASE_LEN == 0) begin
        phase     = phase_kind_t'($urandom_range(0, 2));
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
        for (i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      end
      if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end

      r = $urandom_range(0, 9);
      case (phase)
        PH_FILL:  op = (r < 7) ? ukl_pkg::OP_INSERT :
                       (r < 9) ? ukl_pkg::OP_SEARCH : ukl_pkg::OP_REMOVE;
        PH_DRAIN: op = (r < 7) ? ukl_pkg::OP_REMOVE :
                       (r < 9) ? ukl_pkg::OP_SEARCH : ukl_pkg::OP_INSERT;
        default:  op = (r < 3) ? ukl_pkg::OP_SEARCH : (r < 6) ? ukl_pkg::OP_INSERT :
                       (r < 9) ? ukl_pkg::OP_REMOVE : OP_UNUSED;
      endcase

      // Mostly keys already stored or from a small pool, so hits are frequent.
      r = $urandom_range(0, 9);
      if (r < 5 && table_count > 0) key = table_keys[$urandom_range(0, table_count - 1)];
      else if (r < 8) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else key = $urandom;

      send_item(op, key, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d search, %0d insert, %0d remove and %0d no-op items.",
             op_seen[ukl_pkg::OP_SEARCH], op_seen[ukl_pkg::OP_INSERT],
             op_seen[ukl_pkg::OP_REMOVE], op_seen[OP_UNUSED]);
    $display("Checked %0d results: %0d ok, %0d not found, %0d duplicate, %0d full, %s",
             results_seen, status_seen[ukl_pkg::ST_OK], status_seen[ukl_pkg::ST_NOT_FOUND],
             status_seen[ukl_pkg::ST_DUPLICATE], status_seen[ukl_pkg::ST_FULL],
             $sformatf("%0d empty; %0d errors.", status_seen[ukl_pkg::ST_EMPTY],
                       fail_count));
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
